// File: rtl/serial_command_and_keypad_event_decoder_assert.svh
// assertion macros for the serial command and keypad event decoder
// used by the top level only, expects clk and rst_n in scope
`ifndef SERIAL_COMMAND_AND_KEYPAD_EVENT_DECODER_ASSERT_SVH
`define SERIAL_COMMAND_AND_KEYPAD_EVENT_DECODER_ASSERT_SVH

// same-cycle implication
`define SCKD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCKD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sckd_pkg.sv
// shared types, codes and helper functions for the serial command decoder
// no dependencies
package sckd_pkg;

  localparam int FRAME_DEPTH_DEF = 8;
  localparam int WIN             = 8;
  localparam int VAL_W           = 19;

  localparam logic [2:0] NAV_NONE  = 3'd0;
  localparam logic [2:0] NAV_RIGHT = 3'd1;
  localparam logic [2:0] NAV_LEFT  = 3'd2;
  localparam logic [2:0] NAV_ENTER = 3'd3;
  localparam logic [2:0] NAV_UP    = 3'd4;
  localparam logic [2:0] NAV_DOWN  = 3'd5;

  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_A1_LOW  = 3'd1;
  localparam logic [2:0] KIND_A1_HIGH = 3'd2;
  localparam logic [2:0] KIND_A2_LOW  = 3'd3;
  localparam logic [2:0] KIND_A2_HIGH = 3'd4;
  localparam logic [2:0] KIND_LANG    = 3'd5;
  localparam logic [2:0] KIND_LOOP    = 3'd6;

  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UD    = 8'h44;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_UH    = 8'h48;
  localparam logic [7:0] CH_UI    = 8'h49;
  localparam logic [7:0] CH_UL    = 8'h4C;
  localparam logic [7:0] CH_UN    = 8'h4E;
  localparam logic [7:0] CH_UP    = 8'h50;
  localparam logic [7:0] CH_US    = 8'h53;
  localparam logic [7:0] CH_UT    = 8'h54;
  localparam logic [7:0] CH_UW    = 8'h57;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LD    = 8'h64;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LS    = 8'h73;
  localparam logic [7:0] CH_LW    = 8'h77;

  localparam logic [11:0] KEY_LIM0 = 12'd175;
  localparam logic [11:0] KEY_LIM1 = 12'd390;
  localparam logic [11:0] KEY_LIM2 = 12'd478;
  localparam logic [11:0] KEY_LIM3 = 12'd614;
  localparam logic [11:0] KEY_LIM4 = 12'd860;
  localparam logic [11:0] KEY_LIM5 = 12'd1300;

  typedef logic [WIN-1:0][7:0] frame_win_t;

  typedef struct packed {
    logic [2:0]              kind;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  function automatic logic [2:0] serial_event(input logic [7:0] c);
    logic [2:0] ev;
    case (c) inside
      CH_UD, CH_LD: ev = NAV_RIGHT;
      CH_UA, CH_LA: ev = NAV_LEFT;
      CH_UE, CH_LE: ev = NAV_ENTER;
      CH_UW, CH_LW: ev = NAV_UP;
      CH_US, CH_LS: ev = NAV_DOWN;
      default:      ev = NAV_NONE;
    endcase
    return ev;
  endfunction

  function automatic logic [2:0] key_event(input logic [11:0] k);
    logic [2:0] ev;
    ev = NAV_NONE;
    if (k > KEY_LIM0 && k < KEY_LIM1) ev = NAV_UP;
    else if (k > KEY_LIM1 && k < KEY_LIM2) ev = NAV_RIGHT;
    else if (k > KEY_LIM2 && k < KEY_LIM3) ev = NAV_DOWN;
    else if (k > KEY_LIM3 && k < KEY_LIM4) ev = NAV_LEFT;
    else if (k > KEY_LIM4 && k < KEY_LIM5) ev = NAV_ENTER;
    return ev;
  endfunction

endpackage

// File: rtl/sckd_frame_decode.sv
// frame decoder: turns the first eight frame bytes into a command and value
// depends on sckd_pkg
module sckd_frame_decode
  import sckd_pkg::*;
(
  input  frame_win_t win,
  output cmd_t       cmd
);

  function automatic logic signed [VAL_W-1:0] digit(input logic [7:0] b);
    logic signed [8:0] d;
    d = 9'(signed'(b)) - $signed({1'b0, CH_ZERO});
    return VAL_W'(d);
  endfunction

  function automatic logic signed [VAL_W-1:0] four_digits(input logic [7:0] b0,
                                                          input logic [7:0] b1,
                                                          input logic [7:0] b2,
                                                          input logic [7:0] b3);
    logic signed [VAL_W-1:0] v;
    v = digit(b0) * VAL_W'(1000) + digit(b1) * VAL_W'(100)
      + digit(b2) * VAL_W'(10) + digit(b3);
    return v;
  endfunction

  logic                    is_alarm;
  logic signed [VAL_W-1:0] alarm_val;
  logic signed [VAL_W-1:0] loop_val;

  assign is_alarm = win[1] == CH_UZ && (win[2] == CH_ONE || win[2] == CH_TWO)
                    && (win[3] == CH_UL || win[3] == CH_UH);
  assign alarm_val = four_digits(win[4], win[5], win[6], win[7]);
  assign loop_val  = four_digits(win[2], win[3], win[4], win[5]);

  always_comb begin
    cmd.kind  = KIND_NONE;
    cmd.value = '0;
    if (is_alarm) begin
      cmd.value = alarm_val;
      case ({win[2] == CH_ONE, win[3] == CH_UH})
        2'b10:   cmd.kind = KIND_A1_LOW;
        2'b11:   cmd.kind = KIND_A1_HIGH;
        2'b00:   cmd.kind = KIND_A2_LOW;
        default: cmd.kind = KIND_A2_HIGH;
      endcase
    end else if (win[1] == CH_UP && win[2] == CH_UT) begin
      cmd.kind = KIND_LANG;
    end else if (win[1] == CH_UI && win[2] == CH_UN) begin
      cmd.kind  = KIND_LANG;
      cmd.value = VAL_W'(1);
    end else if (win[1] == CH_UT) begin
      cmd.kind  = KIND_LOOP;
      cmd.value = loop_val;
    end
  end

endmodule

// File: rtl/serial_command_and_keypad_event_decoder.sv
// top level of the serial command and keypad event decoder
// depends on sckd_pkg, sckd_frame_decode and the assertion macro header
//
// One transaction in gives one transaction out. A transaction is taken into an
// input register, then the event, frame store update and command decode are
// done in one pass into the output register, and a new transaction can be
// accepted every cycle; only a stall on the output side slows the block. The
// frame store is flip-flops cleared by reset, so the block is ready right
// after reset.
module serial_command_and_keypad_event_decoder
  import sckd_pkg::*;
#(
  parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_rx_byte,
  input  logic [11:0]             in_key_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              out_event_code,
  output logic [2:0]              out_command_kind,
  output logic signed [VAL_W-1:0] out_command_value
);

  `include "serial_command_and_keypad_event_decoder_assert.svh"

  localparam int POS_W = $clog2(FRAME_DEPTH + 1);
  localparam int IDX_W = $clog2(FRAME_DEPTH);

  logic                    s1_valid_r;
  logic [7:0]              s1_byte_r;
  logic [11:0]             s1_key_r;
  logic                    out_valid_r;
  logic [2:0]              out_event_r;
  logic [2:0]              out_kind_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic [POS_W-1:0]        pos_r;
  logic [POS_W-1:0]        pos_nxt;
  logic [7:0]              store_r [FRAME_DEPTH];
  logic [11:0]             prev_key_r;

  logic                    out_free;
  logic                    s1_adv;
  logic                    in_acc;
  logic [2:0]              sev;
  logic [2:0]              kev;
  logic                    is_frame;
  logic                    wr;
  logic                    frame_end;
  logic                    key_chg;
  logic [2:0]              ev;
  logic [2:0]              kind;
  logic signed [VAL_W-1:0] value;
  frame_win_t              win;
  cmd_t                    cmd;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_rx_byte;
      s1_key_r  <= in_key_sample;
    end
  end

  // decode pass
  assign sev      = serial_event(s1_byte_r);
  assign kev      = key_event(s1_key_r);
  assign is_frame = s1_byte_r != 8'd0 && sev == NAV_NONE;
  assign wr       = is_frame && pos_r < POS_W'(FRAME_DEPTH);

  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      win[i] = (wr && pos_r == POS_W'(i)) ? s1_byte_r : store_r[i];
    end
  end

  sckd_frame_decode u_decode (
    .win (win),
    .cmd (cmd)
  );

  assign frame_end = wr && s1_byte_r == CH_DOT && win[0] == CH_BANG;
  assign key_chg   = s1_key_r != prev_key_r;
  assign ev        = (key_chg && kev != NAV_NONE) ? kev : sev;
  assign kind      = frame_end ? cmd.kind : KIND_NONE;
  assign value     = (kind != KIND_NONE) ? cmd.value : '0;

  always_comb begin
    pos_nxt = pos_r;
    if (is_frame) begin
      if (s1_byte_r == CH_DOT) begin
        pos_nxt = '0;
      end else if (wr) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      prev_key_r <= '0;
      for (int i = 0; i < FRAME_DEPTH; i++) begin
        store_r[i] <= '0;
      end
    end else if (s1_adv) begin
      pos_r      <= pos_nxt;
      prev_key_r <= s1_key_r;
      if (wr) begin
        store_r[pos_r[IDX_W-1:0]] <= s1_byte_r;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_event_r <= ev;
      out_kind_r  <= kind;
      out_value_r <= value;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_code    = out_event_r;
  assign out_command_kind  = out_kind_r;
  assign out_command_value = out_value_r;

  `SCKD_ASSERT_IMP(a_value_zero_no_cmd, out_valid_r && out_kind_r == KIND_NONE,
                   out_value_r == '0, "command value nonzero without a command")
  `SCKD_ASSERT_NXT(a_dot_clears_pos, s1_adv && is_frame && s1_byte_r == CH_DOT,
                   pos_r == '0, "frame end did not clear the position")
  `SCKD_ASSERT_IMP(a_stall_cause, s1_valid_r && !s1_adv,
                   out_valid_r && out_stall, "input stage held without output stall")
  `SCKD_ASSERT_NXT(a_prev_key, s1_adv,
                   prev_key_r == $past(s1_key_r), "previous key not updated")

endmodule
